[hdl/cibuf_pkg.sv]
package cibuf_pkg;

   // default number of byte slots
   localparam int CAPACITY_DEF = 64;

   // cursor control bytes
   localparam logic [7:0] CHAR_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LINK,
      ST_EMPTY,
      ST_WALK
   } state_type;

endpackage

[hdl/cibuf_ram.sv]
module cibuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/cursor_insert_text_buffer_unit.sv]
// Cursor-insert line buffer. Each request item carries one byte of a line: 0x5B moves the
// insertion cursor to the front of the text, 0x5D moves it to the end, and any other byte is
// inserted after the cursor, which then sits on the new byte. Text is held as a singly linked
// list in two single-port-write RAMs (bytes and successor links, slot 0 being the head
// sentinel, whose link lives in a register). An end-of-line item walks the list and returns
// one response item per stored byte, the final one flagged last, then clears the line; an
// empty line gives a single response flagged empty. Bytes past CAPACITY are dropped and
// flag overflowed on that line's responses. A cursor byte or a dropped byte is handled as it
// is accepted; an inserted byte also passes through the link state, because the link RAM has
// one write port and an insert writes two links (the new node's and its predecessor's). An
// end-of-line item reads the first node after it is accepted, then outputs one node at a time,
// each following read overlapped with the previous byte's output, and waits while responses
// are stalled. No clearing pass is needed after reset: only slots 1 up to the fill count are
// ever read, and each was written on its insert. A new request can be taken while the last
// response of a line still waits in the output register.
module cursor_insert_text_buffer_unit #(
   parameter int CAPACITY = cibuf_pkg::CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_empty_line,
   output logic       rsp_overflowed,
   output logic       rsp_last
);

   import cibuf_pkg::*;

   // slot index: 0 is the sentinel, 1..CAPACITY hold bytes; also wide enough for the fill count
   localparam int IW    = $clog2(CAPACITY + 1);
   localparam int SLOTS = CAPACITY + 1;

   localparam logic [IW-1:0] CAP_IDX = IW'(CAPACITY);
   localparam logic [IW-1:0] SENT    = '0;

   // control state
   state_type      state_ff, state_in;
   logic [IW-1:0]  head_ff, head_in;       // sentinel link
   logic [IW-1:0]  tail_ff, tail_in;
   logic [IW-1:0]  cursor_ff, cursor_in;
   logic [IW-1:0]  cnext_ff, cnext_in;     // successor of the cursor node
   logic [IW-1:0]  fill_ff, fill_in;
   logic           ovf_ff, ovf_in;
   logic [IW-1:0]  remain_ff, remain_in;   // nodes still to read in the walk
   logic           first_ff, first_in;     // walk not yet started
   logic           pend_ff, pend_in;       // RAM read data waiting to be taken
   logic           rsp_valid_ff, rsp_valid_in;

   // payload
   logic [IW-1:0]  slot_ff, slot_in;
   logic [7:0]     rsp_char_ff, rsp_char_in;
   logic           rsp_empty_ff, rsp_empty_in;
   logic           rsp_ovf_ff, rsp_ovf_in;
   logic           rsp_last_ff, rsp_last_in;

   // RAM ports
   logic           char_wr_en;
   logic [IW-1:0]  char_wr_addr;
   logic [7:0]     char_wr_data;
   logic [7:0]     char_rd_data;
   logic           link_wr_en;
   logic [IW-1:0]  link_wr_addr;
   logic [IW-1:0]  link_wr_data;
   logic [IW-1:0]  link_rd_data;
   logic           rd_en;
   logic [IW-1:0]  rd_addr;

   logic           req_take;
   logic           out_free;
   logic           consume;
   logic           last_now;

   cibuf_ram #(
      .WIDTH (8),
      .DEPTH (SLOTS)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (char_wr_en),
      .wr_addr (char_wr_addr),
      .wr_data (char_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (char_rd_data)
   );

   cibuf_ram #(
      .WIDTH (IW),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (link_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // walk: the item in the RAM output is final when nothing more is to be read
   // or its link ends the list (the range check only guards a malformed list)
   assign consume  = (state_ff == ST_WALK) && pend_ff && out_free;
   assign last_now = (remain_ff == '0) || (link_rd_data == SENT) || (link_rd_data > CAP_IDX);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cursor_in    = cursor_ff;
      cnext_in     = cnext_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      remain_in    = remain_ff;
      first_in     = first_ff;
      pend_in      = pend_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;

      char_wr_en   = 1'b0;
      char_wr_addr = fill_ff + 1'b1;
      char_wr_data = req_in_char;
      link_wr_en   = 1'b0;
      link_wr_addr = fill_ff + 1'b1;
      link_wr_data = cnext_ff;
      rd_en        = 1'b0;
      rd_addr      = link_rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_end_of_line) begin
                  if (fill_ff == '0) begin
                     state_in = ST_EMPTY;
                  end else begin
                     state_in  = ST_WALK;
                     remain_in = fill_ff;
                     first_in  = 1'b1;
                     pend_in   = 1'b0;
                  end
               end else if (req_in_char == CHAR_OPEN) begin
                  cursor_in = SENT;
                  cnext_in  = head_ff;
               end else if (req_in_char == CHAR_CLOSE) begin
                  cursor_in = tail_ff;
                  cnext_in  = SENT;
               end else if (fill_ff == CAP_IDX) begin
                  ovf_in = 1'b1;
               end else begin
                  // new node takes the cursor's successor; predecessor fixed next cycle
                  char_wr_en = 1'b1;
                  link_wr_en = 1'b1;
                  slot_in    = fill_ff + 1'b1;
                  state_in   = ST_LINK;
               end
            end
         end

         ST_LINK: begin
            if (cursor_ff == SENT) begin
               head_in = slot_ff;
            end else begin
               link_wr_en   = 1'b1;
               link_wr_addr = cursor_ff;
               link_wr_data = slot_ff;
            end
            if (tail_ff == cursor_ff) begin
               tail_in = slot_ff;
            end
            cursor_in = slot_ff;
            fill_in   = fill_ff + 1'b1;
            state_in  = ST_IDLE;
         end

         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_empty_in = 1'b1;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = 1'b1;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         ST_WALK: begin
            if (first_ff) begin
               rd_en     = 1'b1;
               rd_addr   = head_ff;
               remain_in = remain_ff - 1'b1;
               first_in  = 1'b0;
               pend_in   = 1'b1;
            end else if (consume) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = char_rd_data;
               rsp_empty_in = 1'b0;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = last_now;
               if (last_now) begin
                  // line done: clear
                  pend_in   = 1'b0;
                  head_in   = SENT;
                  tail_in   = SENT;
                  cursor_in = SENT;
                  cnext_in  = SENT;
                  fill_in   = '0;
                  ovf_in    = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  // follow the link of the node just taken
                  rd_en     = 1'b1;
                  rd_addr   = link_rd_data;
                  remain_in = remain_ff - 1'b1;
                  pend_in   = 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cursor_ff    <= '0;
         cnext_ff     <= '0;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         remain_ff    <= '0;
         first_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
         cnext_ff     <= cnext_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         remain_ff    <= remain_in;
         first_ff     <= first_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = rsp_char_ff;
   assign rsp_empty_line = rsp_empty_ff;
   assign rsp_overflowed = rsp_ovf_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
